>>> rtl/gfmu_pkg.sv
// Package for the GF(2^8) multiply / inverse unit.
// Holds the field polynomial and the shared reduction function; no dependencies.
`timescale 1ns / 1ps

package gfmu_pkg;

   // Field polynomial x^8 + x^4 + x^3 + x + 1
   localparam logic [8:0] GF_POLY = 9'h11B;

   // Operation codes on the mode field
   localparam logic MODE_MUL = 1'b0;
   localparam logic MODE_INV = 1'b1;

   // Width of a carry-less product of two field elements
   localparam int PROD_W = 15;

   typedef logic [7:0]        gf_elem_type;
   typedef logic [PROD_W-1:0] gf_prod_type;

   // Reduce a 15-bit carry-less product modulo the field polynomial
   function automatic gf_elem_type gf_reduce(input gf_prod_type p);
      gf_prod_type acc;
      gf_prod_type poly_wide;
      acc       = p;
      poly_wide = PROD_W'(GF_POLY);
      for (int i = PROD_W - 1; i >= 8; i--) begin
         if (acc[i]) begin
            acc = acc ^ (poly_wide << (i - 8));
         end
      end
      return acc[7:0];
   endfunction

   // Square a field element: spread the bits, then reduce (pure XOR network)
   function automatic gf_elem_type gf_sq(input gf_elem_type a);
      gf_prod_type spread;
      spread = '0;
      for (int i = 0; i < 8; i++) begin
         spread[2*i] = a[i];
      end
      return gf_reduce(spread);
   endfunction

endpackage

>>> rtl/gfmu_mult.sv
// Combinational GF(2^8) multiplier: carry-less product, then polynomial reduction.
// Depends on gfmu_pkg.
`timescale 1ns / 1ps

module gfmu_mult
   import gfmu_pkg::*;
(
   input  logic [7:0] mul_x,
   input  logic [7:0] mul_y,
   output logic [7:0] mul_p
);

   gf_prod_type clmul;

   // Form the carry-less product from shifted partial products
   always_comb begin
      clmul = '0;
      for (int i = 0; i < 8; i++) begin
         if (mul_y[i]) begin
            clmul = clmul ^ (gf_prod_type'(mul_x) << i);
         end
      end
   end

   // Fold the high bits back into the field
   assign mul_p = gf_reduce(clmul);

endmodule

>>> rtl/gf256_mul_inv_unit.sv
// Top level of the GF(2^8) multiply / inverse unit (AES polynomial 0x11B).
// Four-stage pipeline built from gfmu_mult instances; depends on gfmu_pkg.
//
//   channel | direction | ports                                        | handshake
//   --------+-----------+----------------------------------------------+-----------------------
//   request | in        | req_mode, req_operand_a, req_operand_b       | req_valid / req_ready
//   result  | out       | rsp_field_result                             | rsp_valid / rsp_ready
//
// A result passes four register stages, the first loaded at the accept edge; one item per
// cycle enters while the result port accepts results.
// Each stage holds one GF multiplier: a^3, a^15, a^252, a^254 for an inverse; a multiply
// uses the first stage's multiplier and passes through the rest.
// Synchronous active-high reset clears the stage valid bits; the datapath is not reset.
// A stall at the result port backs up stage by stage; empty stages keep filling.
`timescale 1ns / 1ps

module gf256_mul_inv_unit
   import gfmu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_operand_a,
   input  logic [7:0] req_operand_b,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_field_result
);

   localparam int NUM_STAGES = 4;

   logic [NUM_STAGES-1:0] v_ff, v_in;
   logic [NUM_STAGES-1:0] rdy;

   // Stage registers
   logic        s1_mode_ff, s2_mode_ff, s3_mode_ff;
   gf_elem_type s1_val_ff, s2_val_ff, s3_val_ff, out_ff;
   gf_elem_type s1_a2_ff, s2_a2_ff, s3_a2_ff, s2_a12_ff;

   gf_elem_type s1_val_in, s1_a2_in, s2_val_in, s2_a12_in, s3_val_in, out_in;

   // Multiplier operands and products
   gf_elem_type m1_x, m1_y, m1_p;
   gf_elem_type m2_x, m2_p;
   gf_elem_type m3_x, m3_p;
   gf_elem_type m4_p;

   // Backpressure: a stage loads when empty or when the next one moves
   always_comb begin
      rdy[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign req_ready = rdy[0];

   // Advance valid bits with the data
   always_comb begin
      v_in[0] = rdy[0] ? req_valid : v_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         v_in[i] = rdy[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage 1: a^3 = a^2 * a for inverse, or a * b for multiply
   assign s1_a2_in = gf_sq(req_operand_a);
   assign m1_x     = (req_mode == MODE_INV) ? s1_a2_in : req_operand_a;
   assign m1_y     = (req_mode == MODE_INV) ? req_operand_a : req_operand_b;

   gfmu_mult u_mult1 (.mul_x(m1_x), .mul_y(m1_y), .mul_p(m1_p));

   assign s1_val_in = m1_p;

   // Stage 2: a^15 = (a^3)^4 * a^3
   assign m2_x      = gf_sq(gf_sq(s1_val_ff));
   assign s2_a12_in = m2_x;

   gfmu_mult u_mult2 (.mul_x(m2_x), .mul_y(s1_val_ff), .mul_p(m2_p));

   assign s2_val_in = (s1_mode_ff == MODE_INV) ? m2_p : s1_val_ff;

   // Stage 3: a^252 = (a^15)^16 * a^12
   assign m3_x = gf_sq(gf_sq(gf_sq(gf_sq(s2_val_ff))));

   gfmu_mult u_mult3 (.mul_x(m3_x), .mul_y(s2_a12_ff), .mul_p(m3_p));

   assign s3_val_in = (s2_mode_ff == MODE_INV) ? m3_p : s2_val_ff;

   // Stage 4: a^254 = a^252 * a^2
   gfmu_mult u_mult4 (.mul_x(s3_val_ff), .mul_y(s3_a2_ff), .mul_p(m4_p));

   assign out_in = (s3_mode_ff == MODE_INV) ? m4_p : s3_val_ff;

   // Load each stage's payload when it takes a new item, hold otherwise
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_mode_ff <= req_mode;
         s1_val_ff  <= s1_val_in;
         s1_a2_ff   <= s1_a2_in;
      end
      if (rdy[1]) begin
         s2_mode_ff <= s1_mode_ff;
         s2_val_ff  <= s2_val_in;
         s2_a12_ff  <= s2_a12_in;
         s2_a2_ff   <= s1_a2_ff;
      end
      if (rdy[2]) begin
         s3_mode_ff <= s2_mode_ff;
         s3_val_ff  <= s3_val_in;
         s3_a2_ff   <= s2_a2_ff;
      end
      if (rdy[3]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid        = v_ff[NUM_STAGES-1];
   assign rsp_field_result = out_ff;

   // A ready result port lets the whole pipe move, so the request side is open
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request side stalled while result port is ready");

   // A blocked first stage keeps its item and payload
   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] && !rdy[1] |=> v_ff[0] && $stable(s1_val_ff))
      else $error("stage 1 item lost under stall");

   // A multiply passes the last stage unchanged
   a_mul_bypass: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] && (s3_mode_ff == MODE_MUL) && rdy[3] |=> rsp_field_result == $past(s3_val_ff))
      else $error("multiply result altered in final stage");

   // Reset empties every stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> v_ff == '0)
      else $error("pipeline not empty after reset");

endmodule
